/* rtl/exp_taylor_range_reduced_top_macros.svh */
// Assertion macros shared by the exponential block's RTL files.
// The macros sample on clk and are disabled while rst_n is low.
`ifndef EXP_TAYLOR_RANGE_REDUCED_TOP_MACROS_SVH
`define EXP_TAYLOR_RANGE_REDUCED_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define ETRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define ETRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/etrr_pkg.sv */
// Package for the range-reduced Taylor exponential: widths, codes, command and
// status structs, FSM states and the e^n table function. No dependencies.
package etrr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int INT_RANGE_DEF = 8;

  // Q2.30 working format
  localparam int Q = 30;
  localparam int OUT_FRAC = 20;
  localparam logic [63:0] E_Q30 = 64'd2918732889;
  localparam logic [63:0] E_INV_Q30 = ((64'd1 << 60) + E_Q30 / 64'd2) / E_Q30;

  localparam int MT_W       = 6;
  localparam int TOL_W      = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam logic [MT_W-1:0]  MT_RESET  = 6'd63;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TERMS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_TOL  = 1'd1;

  localparam int TERM_W  = 31;  // term magnitude, up to 2^30
  localparam int ZMAG_W  = 30;  // |z| up to 2^29
  localparam int A_W     = 30;  // dividend of the divide by k
  localparam int SUM_W   = 33;  // signed partial sum
  localparam int E0_W    = 46;  // e^n in Q30, n up to 11
  localparam int MUL_W   = 32;
  localparam int FRAC_W  = 34;  // rounded low partial product
  localparam int PROD_W  = 48;  // e^n * sum in Q30
  localparam int EXP_W   = 32;
  localparam int COUNT_W = 7;

  localparam int DIV_BITS  = 3;
  localparam int DIV_STEPS = A_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_TERM,
    MUL_LO,
    MUL_HI
  } mul_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TERM_ADD,
    S_TERM_MUL,
    S_TERM_SCALE,
    S_TERM_DIV,
    S_FIN_LO,
    S_FIN_HI,
    S_FIN_SUM,
    S_FIN_OUT
  } etrr_state_t;

  typedef struct packed {
    logic    load;
    logic    term_add;
    logic    k_inc;
    logic    div_start;
    logic    term_load;
    mul_op_t mul_op;
    logic    frac_load;
    logic    prod_load;
    logic    out_load;
  } etrr_cmd_t;

  typedef struct packed {
    logic mt_zero;
    logic below_tol;
    logic k_at_max;
    logic div_done;
  } etrr_status_t;

  // e^n in Q30 as |n| successive products, each rounded half up to Q30.
  function automatic logic [E0_W-1:0] exp_int_q30(input int n);
    logic [63:0] p;
    logic [63:0] base;
    logic [63:0] hi;
    logic [63:0] lo;
    int          cnt;
    p    = 64'd1 << Q;
    base = (n >= 0) ? E_Q30 : E_INV_Q30;
    cnt  = (n < 0) ? -n : n;
    for (int i = 0; i < cnt; i++) begin
      hi = p >> Q;
      lo = p & ((64'd1 << Q) - 64'd1);
      p  = hi * base + ((lo * base + (64'd1 << (Q - 1))) >> Q);
    end
    return p[E0_W-1:0];
  endfunction

endpackage

/* rtl/etrr_if.sv */
// Valid/ready channel interfaces for the exponential block: argument in,
// result out. Depends on etrr_pkg for default widths.
interface etrr_in_if #(
  parameter int X_W = etrr_pkg::FRAC_BITS_DEF + 5
);
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

interface etrr_out_if;
  logic                          valid;
  logic                          ready;
  logic [etrr_pkg::EXP_W-1:0]    exp_value;
  logic                          bad_term_count;
  logic [etrr_pkg::COUNT_W-1:0]  terms_summed;

  modport source (output valid, output exp_value, output bad_term_count,
                  output terms_summed, input ready);
  modport sink   (input valid, input exp_value, input bad_term_count,
                  input terms_summed, output ready);
endinterface

/* rtl/etrr_div.sv */
// Iterative unsigned divider for the term update: quotient of a 30-bit value
// by the 6-bit index k, three bits a cycle. Depends on etrr_pkg and the macros.
`include "exp_taylor_range_reduced_top_macros.svh"

module etrr_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [etrr_pkg::A_W-1:0]  dividend,
  input  logic [etrr_pkg::MT_W-1:0] divisor,
  output logic                      done,
  output logic [etrr_pkg::A_W-1:0]  quotient
);
  import etrr_pkg::*;

  logic [A_W-1:0]       quo_r, quo_nxt;
  logic [MT_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  // Restoring steps; dividend bits shift out of quo as quotient bits shift in.
  always_comb begin
    logic [MT_W:0] trial;
    trial   = '0;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial   = {rem_nxt, quo_nxt[A_W-1]};
      quo_nxt = {quo_nxt[A_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial      = trial - {1'b0, divisor};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[MT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `ETRR_ASSERT_NOW(a_div_start_free, start, !busy_r, "divider restarted while busy")
  `ETRR_ASSERT_NOW(a_div_done_end, done_r, $past(busy_r) && !busy_r, "done without a pass")
  `ETRR_ASSERT_NOW(a_div_cnt_fresh, $rose(busy_r), cnt_r == '0, "step count not cleared")

endmodule

/* rtl/etrr_ctrl.sv */
// Controller FSM of the exponential block: sequences the term loop and the
// final scaling, and owns the channel handshakes. Depends on etrr_pkg, macros.
`include "exp_taylor_range_reduced_top_macros.svh"

module etrr_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  etrr_pkg::etrr_status_t status,
  output etrr_pkg::etrr_cmd_t    cmd
);
  import etrr_pkg::*;

  etrr_state_t state_r, state_nxt;
  logic        out_valid_r;
  logic        slot_free;
  logic        series_stop;

  assign slot_free   = !out_valid_r || out_ready;
  assign series_stop = status.below_tol || status.k_at_max;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = status.mt_zero ? S_FIN_OUT : S_TERM_ADD;
      end
      S_TERM_ADD:   state_nxt = series_stop ? S_FIN_LO : S_TERM_MUL;
      S_TERM_MUL:   state_nxt = S_TERM_SCALE;
      S_TERM_SCALE: state_nxt = S_TERM_DIV;
      S_TERM_DIV: begin
        if (status.div_done) state_nxt = S_TERM_ADD;
      end
      S_FIN_LO:  state_nxt = S_FIN_HI;
      S_FIN_HI:  state_nxt = S_FIN_SUM;
      S_FIN_SUM: state_nxt = S_FIN_OUT;
      S_FIN_OUT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:       cmd.load = in_valid;
      S_TERM_ADD: begin
        cmd.term_add = 1'b1;
        cmd.k_inc    = !series_stop;
      end
      S_TERM_MUL:   cmd.mul_op = MUL_TERM;
      S_TERM_SCALE: cmd.div_start = 1'b1;
      S_TERM_DIV:   cmd.term_load = status.div_done;
      S_FIN_LO:     cmd.mul_op = MUL_LO;
      S_FIN_HI: begin
        cmd.mul_op    = MUL_HI;
        cmd.frac_load = 1'b1;
      end
      S_FIN_SUM:    cmd.prod_load = 1'b1;
      S_FIN_OUT:    cmd.out_load = slot_free;
      default:      cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      priority if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready)        out_valid_r <= 1'b0;
      else                       out_valid_r <= out_valid_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `ETRR_ASSERT_NOW(a_out_slot_free, cmd.out_load, !out_valid_r || out_ready, "result lost")
  `ETRR_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_r != S_IDLE, "accept ignored")
  `ETRR_ASSERT_NEXT(a_term_then_add, cmd.term_load, state_r == S_TERM_ADD, "term not summed")

endmodule

/* rtl/etrr_datapath.sv */
// Datapath of the exponential block: config registers, range reduction, one
// shared 32x32 multiplier, term/sum registers, final scaling and result
// register. Depends on etrr_pkg and etrr_div.
module etrr_datapath #(
  parameter int FRAC_BITS = etrr_pkg::FRAC_BITS_DEF,
  parameter int INT_RANGE = etrr_pkg::INT_RANGE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [etrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [etrr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [FRAC_BITS+4:0]     in_x,
  input  etrr_pkg::etrr_cmd_t             cmd,
  output etrr_pkg::etrr_status_t          status,
  output logic [etrr_pkg::EXP_W-1:0]      out_exp,
  output logic                            out_bad,
  output logic [etrr_pkg::COUNT_W-1:0]    out_terms
);
  import etrr_pkg::*;

  localparam int X_W   = FRAC_BITS + 5;
  localparam int N_W   = $clog2(INT_RANGE + 1);
  localparam int E0_N  = 2 * INT_RANGE + 1;
  localparam int IDX_W = $clog2(E0_N);
  localparam int RND_SH = Q - OUT_FRAC;
  localparam logic signed [X_W-1:0] X_LIM = X_W'(INT_RANGE * (2 ** FRAC_BITS));

  // configuration
  logic [MT_W-1:0]  max_terms_r;
  logic [TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_terms_r <= MT_RESET;
      tol_r       <= TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_TERMS: max_terms_r <= cfg_data[MT_W-1:0];
        CFG_STOP_TOL:  tol_r       <= cfg_data[TOL_W-1:0];
        default:       ;
      endcase
    end
  end

  // e^n table, indexed by n + INT_RANGE
  logic [E0_W-1:0] e0_tbl [E0_N];
  for (genvar g = 0; g < E0_N; g++) begin : g_e0
    localparam logic [E0_W-1:0] E0_VAL = exp_int_q30(g - INT_RANGE);
    assign e0_tbl[g] = E0_VAL;
  end

  // range reduction: x0 = round half away from zero, z = x - x0
  logic signed [X_W-1:0]  x_sat;
  logic                   x_neg;
  logic [X_W-1:0]         x_mag;
  logic [FRAC_BITS-1:0]   frac;
  logic                   round_up;
  logic [N_W-1:0]         n_int;
  logic [FRAC_BITS-1:0]   r_mag;
  logic                   z_neg_nxt;
  logic [IDX_W-1:0]       e0_idx;

  always_comb begin
    if (in_x > X_LIM)       x_sat = X_LIM;
    else if (in_x < -X_LIM) x_sat = -X_LIM;
    else                    x_sat = in_x;
    x_neg     = x_sat[X_W-1];
    x_mag     = x_neg ? X_W'(-x_sat) : X_W'(x_sat);
    frac      = x_mag[FRAC_BITS-1:0];
    round_up  = frac[FRAC_BITS-1];
    n_int     = x_mag[FRAC_BITS +: N_W] + N_W'(round_up);
    r_mag     = round_up ? (~frac + FRAC_BITS'(1)) : frac;
    z_neg_nxt = (r_mag != '0) && (round_up ^ x_neg);
    e0_idx    = x_neg ? (IDX_W'(INT_RANGE) - IDX_W'(n_int))
                      : (IDX_W'(INT_RANGE) + IDX_W'(n_int));
  end

  // series state
  logic                      err_r;
  logic                      z_neg_r;
  logic [ZMAG_W-1:0]         zmag_r;
  logic [E0_W-1:0]           e0_r;
  logic [TERM_W-1:0]         tmag_r;
  logic                      tneg_r;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [SUM_W-1:0]   term_ext;
  logic [MT_W-1:0]           k_r;
  logic [COUNT_W-1:0]        count_r;

  // shared multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_r;
  logic [MUL_W-1:0]   sum_pos;

  // final scaling
  logic [2*MUL_W-1:0] scaled, frac_full;
  logic [A_W-1:0]     div_q;
  logic               div_done;
  logic [FRAC_W-1:0]  frac_r;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [PROD_W:0]    round_sum;
  logic [PROD_W-RND_SH:0] res_w;
  logic [EXP_W-1:0]   res_sat;

  assign term_ext = {{(SUM_W-TERM_W){1'b0}}, tmag_r};
  assign sum_nxt  = tneg_r ? (sum_r - term_ext) : (sum_r + term_ext);
  assign sum_pos  = sum_r[SUM_W-1] ? '0 : sum_r[MUL_W-1:0];

  always_comb begin
    unique case (cmd.mul_op)
      MUL_TERM: begin
        mul_a = MUL_W'(tmag_r);
        mul_b = MUL_W'(zmag_r);
      end
      MUL_LO: begin
        mul_a = MUL_W'(e0_r[Q-1:0]);
        mul_b = sum_pos;
      end
      MUL_HI: begin
        mul_a = MUL_W'(e0_r[E0_W-1:Q]);
        mul_b = sum_pos;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round(t*z / (k*2^30)) = floor(floor((t*z + k*2^29) / 2^30) / k)
  assign scaled    = mul_r + ((2*MUL_W)'(k_r) << (Q - 1));
  assign frac_full = mul_r + ((2*MUL_W)'(1) << (Q - 1));
  assign prod_nxt  = mul_r[PROD_W-1:0] + {{(PROD_W-FRAC_W){1'b0}}, frac_r};
  assign round_sum = {1'b0, prod_r} + (PROD_W+1)'(1 << (RND_SH - 1));
  assign res_w     = round_sum[PROD_W:RND_SH];
  assign res_sat   = (|res_w[PROD_W-RND_SH:EXP_W]) ? '1 : res_w[EXP_W-1:0];

  etrr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (scaled[Q +: A_W]),
    .divisor  (k_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r   <= (max_terms_r == '0);
      z_neg_r <= z_neg_nxt;
      zmag_r  <= {r_mag, {(ZMAG_W-FRAC_BITS){1'b0}}};
      e0_r    <= e0_tbl[e0_idx];
      tmag_r  <= TERM_W'(1) << Q;
      tneg_r  <= 1'b0;
      sum_r   <= '0;
      k_r     <= '0;
      count_r <= '0;
    end else begin
      if (cmd.term_add) begin
        sum_r   <= sum_nxt;
        count_r <= count_r + COUNT_W'(1);
      end
      if (cmd.k_inc) k_r <= k_r + MT_W'(1);
      if (cmd.term_load) begin
        tmag_r <= {1'b0, div_q};
        tneg_r <= tneg_r ^ z_neg_r;
      end
    end
    if (cmd.mul_op != MUL_NONE) mul_r <= mul_a * mul_b;
    if (cmd.frac_load) frac_r <= frac_full[Q +: FRAC_W];
    if (cmd.prod_load) prod_r <= prod_nxt;
  end

  // result register
  logic [EXP_W-1:0]   out_exp_r;
  logic               out_bad_r;
  logic [COUNT_W-1:0] out_terms_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_exp_r   <= err_r ? '0 : res_sat;
      out_bad_r   <= err_r;
      out_terms_r <= count_r;
    end
  end

  assign out_exp   = out_exp_r;
  assign out_bad   = out_bad_r;
  assign out_terms = out_terms_r;

  assign status.mt_zero   = (max_terms_r == '0);
  assign status.below_tol = (tmag_r < tol_r);
  assign status.k_at_max  = (k_r == max_terms_r);
  assign status.div_done  = div_done;

endmodule

/* rtl/exp_taylor_range_reduced_top.sv */
// Top level of the range-reduced Taylor exponential, e^x in Q12.20.
// Depends on etrr_pkg, etrr_if, etrr_ctrl, etrr_datapath (and etrr_div).
//
// Usage:
//   in_ch  (valid/ready): x_value, signed Q4.FRAC_BITS; values past
//          +-INT_RANGE saturate. A transaction is taken only while idle.
//   out_ch (valid/ready): exp_value (Q12.20, saturating at all ones),
//          bad_term_count (max_terms was zero), terms_summed.
//   cfg_*: write port, index 0 = max_terms, 1 = stop_tolerance (Q1.30);
//          write only while no item is in flight.
// A new item enters only once the last one has reached the result register;
// each term runs the add, the multiply, the scale step and the divide by k
// (3 quotient bits a cycle). With the reset tolerance, T = terms_summed is
// about 11 for |z| near one half. A max_terms of zero skips the series and
// gives the error result.
// Reset: max_terms = 63, stop_tolerance = 1, both channels empty.
// Stall: the result register holds a finished transaction while out_ch is
// blocked; the next item is still taken and runs up to its final stage,
// then waits there for the register to drain.
module exp_taylor_range_reduced_top #(
  parameter int FRAC_BITS = etrr_pkg::FRAC_BITS_DEF,
  parameter int INT_RANGE = etrr_pkg::INT_RANGE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  etrr_in_if.sink                         in_ch,
  etrr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [etrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [etrr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import etrr_pkg::*;

  etrr_cmd_t    cmd;
  etrr_status_t status;

  // FSM: handshakes and sequencing
  etrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, config registers and result register
  etrr_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .INT_RANGE (INT_RANGE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_x      (in_ch.x_value),
    .cmd       (cmd),
    .status    (status),
    .out_exp   (out_ch.exp_value),
    .out_bad   (out_ch.bad_term_count),
    .out_terms (out_ch.terms_summed)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for exp_taylor_range_reduced_top: drives signed Q4.16
// arguments, predicts e^x in Q12.20 with 64-bit integer math and checks each result.
// Depends on etrr_pkg and the etrr_in_if / etrr_out_if channel interfaces.
module tb;

  typedef longint unsigned u64_t;

  localparam int FRAC = etrr_pkg::FRAC_BITS_DEF;
  localparam int XW = FRAC + 5;
  localparam int ARG_LIMIT = etrr_pkg::INT_RANGE_DEF << FRAC;
  localparam int FIX = 30;                        // Q2.30 working format
  localparam u64_t E_FIX = 64'd2918732889;        // e in Q30
  localparam u64_t E_RECIP = ((64'd1 << 60) + E_FIX / 2) / E_FIX;
  localparam int TARGET_ITEMS = 1950;
  localparam int LONG_HOLD = 2500;
  localparam longint CYCLE_LIMIT = 8000000;

  typedef struct packed {
    logic [etrr_pkg::EXP_W-1:0]   exp_value;
    logic                         bad_term_count;
    logic [etrr_pkg::COUNT_W-1:0] terms_summed;
  } exp_result_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [etrr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [etrr_pkg::CFG_DATA_W-1:0] cfg_data;

  etrr_in_if #(.X_W(XW)) arg_ch ();
  etrr_out_if            res_ch ();

  exp_taylor_range_reduced_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (arg_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies used by the predictor; they change only while the block is idle.
  logic [etrr_pkg::MT_W-1:0]  terms_cfg = etrr_pkg::MT_RESET;
  logic [etrr_pkg::TOL_W-1:0] tol_cfg   = etrr_pkg::TOL_RESET;

  logic signed [XW-1:0] arg_queue [$];   // arguments waiting for the driver
  exp_result_t          exp_due   [$];   // predicted results, oldest first
  exp_result_t          due_result;

  int     fail_count    = 0;
  int     sent_count    = 0;
  int     recv_count    = 0;
  int     error_results = 0;
  int     sat_args      = 0;
  int     phase_count   = 1;
  int     send_gap      = 0;
  int     stall_left    = 0;
  int     hold_left     = 0;
  int     hold_seen     = 0;
  longint cycle_count   = 0;
  bit     quiet_mode    = 1'b0;

  // Arguments for the directed part: zero, one LSB either way, whole numbers,
  // both sides of a half, exact halves (round away from zero), the saturation
  // edges at +-8, just past them, and the extremes of the 21-bit field.
  int directed_args [0:19] = '{
    0, 1, -1, 65536, -65536, 32767, 32768, -32768, 163840, -163840,
    491520, -491520, 524288, -524288, 524289, -524289, 1048575, -1048576,
    212992, -376832
  };

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  // a * b rounded half up to Q30
  function automatic u64_t mul_round(input u64_t a, input u64_t b);
    u64_t hi;
    u64_t lo;
    hi = a >> FIX;
    lo = a & ((u64_t'(1) << FIX) - 1);
    return hi * b + ((lo * b + (u64_t'(1) << (FIX - 1))) >> FIX);
  endfunction

  // e^n in Q30 as |n| rounded products of e or 1/e
  function automatic u64_t exp_of_int(input int n);
    u64_t p;
    u64_t base;
    int   cnt;
    p    = u64_t'(1) << FIX;
    base = (n >= 0) ? E_FIX : E_RECIP;
    cnt  = (n < 0) ? -n : n;
    for (int i = 0; i < cnt; i++) p = mul_round(p, base);
    return p;
  endfunction

  function automatic exp_result_t predict_exp(input logic signed [XW-1:0] arg);
    exp_result_t r;
    longint      x;
    longint      z;
    longint      sum;
    u64_t        mag;
    u64_t        n;
    u64_t        zmag;
    u64_t        tmag;
    u64_t        den;
    u64_t        prod;
    u64_t        rounded;
    bit          xneg;
    bit          zneg;
    bit          tneg;
    int          count;
    r = '0;
    if (terms_cfg == 0) begin
      r.bad_term_count = 1'b1;
      return r;
    end
    x = arg;
    if (x > ARG_LIMIT) x = ARG_LIMIT;
    if (x < -ARG_LIMIT) x = -ARG_LIMIT;
    // split x into its nearest integer (halves away from zero) and the rest
    xneg = x < 0;
    mag  = xneg ? -x : x;
    n    = (mag + (u64_t'(1) << (FRAC - 1))) >> FRAC;
    z    = x - (xneg ? -longint'(n) : longint'(n)) * (longint'(1) << FRAC);
    z    = z * (longint'(1) << (FIX - FRAC));
    zneg = z < 0;
    zmag = zneg ? -z : z;
    // series for e^z: each term from the last, stop once one falls under tolerance
    tmag  = u64_t'(1) << FIX;
    tneg  = 1'b0;
    sum   = 0;
    count = 0;
    for (int k = 0; k <= terms_cfg; k++) begin
      if (k > 0) begin
        den  = u64_t'(k) << FIX;
        tmag = (tmag * zmag + den / 2) / den;
        tneg = tneg ^ zneg;
      end
      sum += tneg ? -longint'(tmag) : longint'(tmag);
      count++;
      if (tmag < tol_cfg) break;
    end
    if (sum < 0) sum = 0;
    prod    = mul_round(exp_of_int(xneg ? -int'(n) : int'(n)), u64_t'(sum));
    rounded = (prod + (u64_t'(1) << 9)) >> 10;
    if (rounded > 64'hFFFF_FFFF) rounded = 64'hFFFF_FFFF;
    r.exp_value    = rounded[31:0];
    r.terms_summed = count[6:0];
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Random helpers
  // ------------------------------------------------------------------

  // Idle length: mostly none, sometimes short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 60);
  endfunction

  function automatic logic signed [XW-1:0] random_arg();
    int sel;
    int v;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      // whole field, about half of it outside +-8
      v = $urandom;
    end else if (sel == 1) begin
      // exact half between two integers
      v = ($urandom_range(0, 7) << FRAC) + (1 << (FRAC - 1));
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      v = int'($urandom_range(0, 2 * ARG_LIMIT)) - ARG_LIMIT;
    end
    return XW'(v);
  endfunction

  // ------------------------------------------------------------------
  // Clock, driver, monitor, watchdog
  // ------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: predict on each accepted transaction, then offer the next argument
  // once the random gap has run out. Hold valid and data while ready is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      arg_ch.valid <= 1'b0;
    end else begin
      if (arg_ch.valid && arg_ch.ready) begin
        exp_due.push_back(predict_exp(arg_ch.x_value));
        sent_count++;
        if (arg_ch.x_value > ARG_LIMIT || arg_ch.x_value < -ARG_LIMIT) sat_args++;
      end
      if (!arg_ch.valid || arg_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          arg_ch.valid <= 1'b0;
        end else if (arg_queue.size() > 0) begin
          arg_ch.valid   <= 1'b1;
          arg_ch.x_value <= arg_queue.pop_front();
          send_gap = idle_len();
        end else begin
          arg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold: after the 300th and the 1100th result transaction,
  // keep ready low until the LONG_HOLD countdown ends, so the result register
  // fills and the block stalls its input while the driver keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (res_ch.valid && res_ch.ready) begin
      hold_seen <= hold_seen + 1;
      if (hold_seen == 299 || hold_seen == 1099) hold_left <= LONG_HOLD;
      else if (hold_left > 0) hold_left <= hold_left - 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each result transaction with the oldest prediction, and
  // drive ready with random stalls; the long hold comes from its own counter.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        recv_count++;
        if (res_ch.bad_term_count) error_results++;
        if (exp_due.size() == 0) begin
          $error("unexpected result: exp_value %0d, terms_summed %0d",
                 res_ch.exp_value, res_ch.terms_summed);
          fail_count++;
        end else begin
          due_result = exp_due.pop_front();
          if (res_ch.exp_value !== due_result.exp_value) begin
            $error("exp_value: expected %0d, got %0d",
                   due_result.exp_value, res_ch.exp_value);
            fail_count++;
          end
          if (res_ch.bad_term_count !== due_result.bad_term_count) begin
            $error("bad_term_count: expected %0d, got %0d",
                   due_result.bad_term_count, res_ch.bad_term_count);
            fail_count++;
          end
          if (res_ch.terms_summed !== due_result.terms_summed) begin
            $error("terms_summed: expected %0d, got %0d",
                   due_result.terms_summed, res_ch.terms_summed);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------

  // Wait until every argument is sent and every result is back, then hold
  // for the given number of cycles.
  task automatic settle(input int cycles);
    @(negedge clk);
    while (arg_queue.size() != 0 || arg_ch.valid || exp_due.size() != 0) @(negedge clk);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [etrr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [etrr_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == etrr_pkg::CFG_MAX_TERMS) terms_cfg = val[etrr_pkg::MT_W-1:0];
    else tol_cfg = val[etrr_pkg::TOL_W-1:0];
  endtask

  // Settle, then load both registers; the block is idle at this point.
  task automatic set_regs(input int mt, input int unsigned tol, input bit quiet);
    settle(8);
    write_reg(etrr_pkg::CFG_MAX_TERMS, mt);
    write_reg(etrr_pkg::CFG_STOP_TOL, tol);
    @(negedge clk);
    quiet_mode = quiet;
    phase_count++;
  endtask

  task automatic queue_random(input int count);
    @(negedge clk);
    repeat (count) arg_queue.push_back(random_arg());
  endtask

  task automatic queue_directed();
    @(negedge clk);
    foreach (directed_args[i]) arg_queue.push_back(XW'(directed_args[i]));
  endtask

  initial begin : stimulus
    int          planned;
    int          mt;
    int          count;
    int unsigned tol;
    int unsigned shift;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    arg_ch.valid   = 1'b0;
    arg_ch.x_value = '0;
    res_ch.ready   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: directed arguments, then a long random run that also
    // carries the first long receiver hold.
    queue_directed();
    queue_random(480);
    planned = 500;

    // max_terms zero: every result is the error result.
    set_regs(0, 1, 1'b0);
    queue_directed();
    queue_random(20);
    planned += 40;

    // max_terms of one: at most two terms are summed.
    set_regs(1, 1, 1'b0);
    queue_random(60);
    planned += 60;

    // Zero tolerance: the series always runs to the full 64 terms.
    set_regs(63, 0, 1'b0);
    queue_directed();
    planned += 20;

    // Tolerance of exactly one, and the largest the register holds.
    set_regs(5, 32'd1 << 30, 1'b0);
    queue_random(40);
    planned += 40;
    set_regs(63, 32'h7FFF_FFFF, 1'b0);
    queue_random(40);
    planned += 40;

    // Back-to-back stretch with no idling on either side.
    set_regs(2, 0, 1'b1);
    queue_random(40);
    planned += 40;

    // Random settings; keep zero-tolerance phases with many terms short.
    while (planned < TARGET_ITEMS) begin
      mt = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 63);
      case ($urandom_range(0, 9))
        0: tol = 0;
        1: tol = 32'd1 << 30;
        default: begin
          shift = $urandom_range(0, 29);
          tol   = $urandom_range(1, 32'd1 << shift);
        end
      endcase
      count = (tol == 0 && mt > 16) ? 15 : 150;
      if (count > TARGET_ITEMS - planned) count = TARGET_ITEMS - planned;
      set_regs(mt, tol, $urandom_range(0, 3) == 0);
      queue_random(count);
      planned += count;
    end

    // Drain: allow the longest series time to show any stray result.
    settle(1000);
    $display("Sent %0d arguments (%0d beyond +-8) over %0d register settings.",
             sent_count, sat_args, phase_count);
    $display("Checked %0d results, %0d of them error results.", recv_count, error_results);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/etrr_pkg.sv
rtl/etrr_if.sv
rtl/etrr_div.sv
rtl/etrr_ctrl.sv
rtl/etrr_datapath.sv
rtl/exp_taylor_range_reduced_top.sv
tb/tb.sv
